// File: rtl/core/wsf_pkg.sv
package wsf_pkg;

   localparam int CSR_AW = 5;
   localparam int TAG_BITS = 10;

   localparam logic [2:0] REG_FRAME = 3'd0;
   localparam logic [2:0] REG_MAIN  = 3'd1;
   localparam logic [2:0] REG_MID   = 3'd2;
   localparam logic [2:0] REG_FAR   = 3'd3;
   localparam logic [2:0] REG_SIDE  = 3'd4;

   localparam logic [10:0] FRAME_RESET = 11'd512;
   localparam logic [6:0]  MAIN_RESET  = 7'd60;
   localparam logic [6:0]  MID_RESET   = 7'd30;
   localparam logic [6:0]  FAR_RESET   = 7'd10;
   localparam logic [6:0]  SIDE_RESET  = 7'd3;

   // x / 100 == ((x >> 2) * DIV_K) >> DIV_SHIFT for x below 2**23
   localparam int DIV_PRE = 2;
   localparam int DIV_SHIFT = 30;
   localparam int DIV_K_BITS = 26;
   localparam logic [DIV_K_BITS-1:0] DIV_K = 26'd42949673;

   typedef struct packed {
      logic [6:0] w_main;
      logic [6:0] w_mid;
      logic [6:0] w_far;
      logic [6:0] w_side;
   } wgt_type;

   typedef struct packed {
      logic [TAG_BITS-1:0] row;
      logic [TAG_BITS-1:0] col;
      logic                last;
   } tag_type;

   function automatic logic [6:0] tap_weight(input wgt_type w, input int unsigned t);
      logic [6:0] r;
      case (t)
         0: r = w.w_main;
         4: r = w.w_mid;
         8: r = w.w_far;
         1, 3, 5, 7: r = w.w_side;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/wsf_ifs.sv
interface wsf_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_red;
   logic [15:0] pixel_green;
   logic [15:0] pixel_blue;
   modport source(output valid, pixel_red, pixel_green, pixel_blue, input ready);
   modport sink(input valid, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface wsf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_red;
   logic [15:0] out_green;
   logic [15:0] out_blue;
   logic [9:0]  out_row;
   logic [9:0]  out_col;
   logic        burst_last;
   modport source(output valid, out_red, out_green, out_blue, out_row, out_col, burst_last,
                  input ready);
   modport sink(input valid, out_red, out_green, out_blue, out_row, out_col, burst_last,
                output ready);
endinterface

// File: rtl/core/weighted_3x3_stencil_filter_top.sv
// an accepted pixel passes the input register, the window sequencer and the product,
// quotient and output registers; throughput: one pixel per cycle while no burst or
// output back-pressure holds the input, a beat per output; a last-column or last-row
// pixel, like the frame-end pixel, holds the input while the window sequencer walks its burst
// reset: counters, window and handshakes cleared, registers to defaults;
// line store contents are kept and stale entries never reach an output
module weighted_3x3_stencil_filter_top #(
   parameter int MAX_FRAME = 1024,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   wsf_req_if.sink                     req_bus,
   wsf_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wsf_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int CB = CHANNEL_BITS;
   localparam int PW = 3 * CB;
   localparam int CW = $clog2(MAX_FRAME);

   logic [10:0]       frame_ff;
   wsf_pkg::wgt_type  wgt_ff;
   logic              csr_wr;
   logic [2:0]        csr_idx;
   logic [31:0]       n32;
   logic [CW-1:0]     n_m1;
   logic [CW-1:0]     row_ff, col_ff;
   logic              accept;

   logic              v0_ff;
   logic [PW-1:0]     px0_ff;
   logic [CW-1:0]     r0_ff, c0_ff;
   logic              fwd_v_ff;
   logic [2*PW-1:0]   fwd_d_ff;
   logic [2*PW-1:0]   ram_q, rd;
   logic [PW-1:0]     rd_older, rd_newer;
   logic              s0_adv;

   logic              busy_ff;
   logic [1:0]        di_ff, dj_ff, dj_lo_ff, hi_r_ff, hi_c_ff;
   logic [CW-1:0]     sr_ff, sc_ff;
   logic              issue, last_item, mac_ready;
   logic              lr, lc, r_ge2, c_ge2, has_out;
   logic [1:0]        di_lo, dj_lo;

   logic [PW-1:0]     win_ff [9];
   logic [PW-1:0]     taps [9];
   wsf_pkg::tag_type  tag;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= wsf_pkg::FRAME_RESET;
         wgt_ff.w_main <= wsf_pkg::MAIN_RESET;
         wgt_ff.w_mid <= wsf_pkg::MID_RESET;
         wgt_ff.w_far <= wsf_pkg::FAR_RESET;
         wgt_ff.w_side <= wsf_pkg::SIDE_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            wsf_pkg::REG_FRAME: frame_ff <= csr_pwdata[10:0];
            wsf_pkg::REG_MAIN:  wgt_ff.w_main <= csr_pwdata[6:0];
            wsf_pkg::REG_MID:   wgt_ff.w_mid <= csr_pwdata[6:0];
            wsf_pkg::REG_FAR:   wgt_ff.w_far <= csr_pwdata[6:0];
            wsf_pkg::REG_SIDE:  wgt_ff.w_side <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         wsf_pkg::REG_FRAME: csr_prdata = 32'(frame_ff);
         wsf_pkg::REG_MAIN:  csr_prdata = 32'(wgt_ff.w_main);
         wsf_pkg::REG_MID:   csr_prdata = 32'(wgt_ff.w_mid);
         wsf_pkg::REG_FAR:   csr_prdata = 32'(wgt_ff.w_far);
         wsf_pkg::REG_SIDE:  csr_prdata = 32'(wgt_ff.w_side);
         default: csr_prdata = '0;
      endcase
   end

   // effective frame size
   always_comb begin
      if (frame_ff == 11'd0) begin
         n32 = 32'd1;
      end else if (32'(frame_ff) > 32'(MAX_FRAME)) begin
         n32 = 32'(MAX_FRAME);
      end else begin
         n32 = 32'(frame_ff);
      end
   end
   assign n_m1 = CW'(n32 - 32'd1);

   assign accept = req_bus.valid & req_bus.ready;
   assign req_bus.ready = !v0_ff | s0_adv;

   always_ff @(posedge clock) begin
      if (reset || (csr_wr && csr_idx == wsf_pkg::REG_FRAME)) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (col_ff == n_m1) begin
            col_ff <= '0;
            row_ff <= (row_ff == n_m1) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // line stores: older row in the upper half, newer row in the lower half
   wsf_ram #(.WIDTH(2*PW), .DEPTH(MAX_FRAME)) u_lines (
      .clock   (clock),
      .wr_en   (s0_adv),
      .wr_addr (c0_ff),
      .wr_data ({rd_newer, px0_ff}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_q)
   );

   assign rd = fwd_v_ff ? fwd_d_ff : ram_q;
   assign rd_older = rd[2*PW-1:PW];
   assign rd_newer = rd[PW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else if (accept) begin
         v0_ff <= 1'b1;
         fwd_v_ff <= s0_adv && (c0_ff == col_ff);
      end else if (s0_adv) begin
         v0_ff <= 1'b0;
      end
      if (accept) begin
         px0_ff <= {req_bus.pixel_blue[CB-1:0], req_bus.pixel_green[CB-1:0],
                    req_bus.pixel_red[CB-1:0]};
         r0_ff <= row_ff;
         c0_ff <= col_ff;
         fwd_d_ff <= {rd_newer, px0_ff};
      end
   end

   // burst descriptor of the pixel in flight
   assign lr = (r0_ff == n_m1);
   assign lc = (c0_ff == n_m1);
   assign r_ge2 = (r0_ff >= CW'(2));
   assign c_ge2 = (c0_ff >= CW'(2));
   assign has_out = (lr | r_ge2) & (lc | c_ge2);
   assign di_lo = r_ge2 ? 2'd0 : 2'd2 - r0_ff[1:0];
   assign dj_lo = c_ge2 ? 2'd0 : 2'd2 - c0_ff[1:0];

   assign last_item = (di_ff == hi_r_ff) && (dj_ff == hi_c_ff);
   assign issue = busy_ff & mac_ready;
   assign s0_adv = v0_ff & (!busy_ff | (issue & last_item));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (s0_adv) begin
         busy_ff <= has_out;
      end else if (issue && last_item) begin
         busy_ff <= 1'b0;
      end
      if (s0_adv) begin
         di_ff <= di_lo;
         dj_ff <= dj_lo;
         dj_lo_ff <= dj_lo;
         hi_r_ff <= lr ? 2'd2 : 2'd0;
         hi_c_ff <= lc ? 2'd2 : 2'd0;
         sr_ff <= r0_ff;
         sc_ff <= c0_ff;
      end else if (issue && !last_item) begin
         if (dj_ff == hi_c_ff) begin
            dj_ff <= dj_lo_ff;
            di_ff <= di_ff + 2'd1;
         end else begin
            dj_ff <= dj_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < 9; t++) begin
            win_ff[t] <= '0;
         end
      end else if (s0_adv) begin
         for (int a = 0; a < 3; a++) begin
            win_ff[a*3]   <= win_ff[a*3+1];
            win_ff[a*3+1] <= win_ff[a*3+2];
         end
         win_ff[2] <= rd_older;
         win_ff[5] <= rd_newer;
         win_ff[8] <= px0_ff;
      end
   end

   // taps past the frame edge contribute nothing
   always_comb begin
      logic [2:0] ra, cb;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            ra = 3'(di_ff) + 3'(a);
            cb = 3'(dj_ff) + 3'(b);
            if (ra > 3'd2 || cb > 3'd2) begin
               taps[a*3+b] = '0;
            end else begin
               taps[a*3+b] = win_ff[4'(ra) * 4'd3 + 4'(cb)];
            end
         end
      end
   end

   assign tag.row = wsf_pkg::TAG_BITS'(sr_ff + CW'(di_ff) - CW'(2));
   assign tag.col = wsf_pkg::TAG_BITS'(sc_ff + CW'(dj_ff) - CW'(2));
   assign tag.last = last_item;

   wsf_mac #(.CHANNEL_BITS(CB)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (busy_ff),
      .in_ready (mac_ready),
      .taps     (taps),
      .tag      (tag),
      .wgt      (wgt_ff),
      .rsp      (rsp_bus)
   );

endmodule

// File: rtl/core/wsf_ram.sv
module wsf_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/wsf_mac.sv
module wsf_mac #(
   parameter int CHANNEL_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [3*CHANNEL_BITS-1:0]   taps [9],
   input  wsf_pkg::tag_type            tag,
   input  wsf_pkg::wgt_type            wgt,
   wsf_rsp_if.source                   rsp
);

   localparam int CB = CHANNEL_BITS;
   localparam int PB = CB + 7;
   localparam int MW = PB - wsf_pkg::DIV_PRE + wsf_pkg::DIV_K_BITS;

   logic              p_v_ff;
   logic [PB-1:0]     prod_ff [9][3];
   wsf_pkg::tag_type  ptag_ff;
   logic              q_v_ff;
   logic [CB-1:0]     quo_ff [9][3];
   wsf_pkg::tag_type  qtag_ff;
   logic              p_rdy, q_rdy, o_rdy;
   logic [MW-1:0]     mul [9][3];
   logic [CB-1:0]     sum [3];

   assign o_rdy = !rsp.valid | rsp.ready;
   assign q_rdy = !q_v_ff | o_rdy;
   assign p_rdy = !p_v_ff | q_rdy;
   assign in_ready = p_rdy;

   // weight products
   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (p_rdy) begin
         p_v_ff <= in_valid;
      end
      if (p_rdy && in_valid) begin
         ptag_ff <= tag;
         for (int t = 0; t < 9; t++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[t][k] <= PB'(taps[t][k*CB +: CB]) *
                                PB'(wsf_pkg::tap_weight(wgt, t));
            end
         end
      end
   end

   // divide by 100 through the reciprocal
   always_comb begin
      for (int t = 0; t < 9; t++) begin
         for (int k = 0; k < 3; k++) begin
            mul[t][k] = MW'(prod_ff[t][k] >> wsf_pkg::DIV_PRE) * MW'(wsf_pkg::DIV_K);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_v_ff <= 1'b0;
      end else if (q_rdy) begin
         q_v_ff <= p_v_ff;
      end
      if (q_rdy && p_v_ff) begin
         qtag_ff <= ptag_ff;
         for (int t = 0; t < 9; t++) begin
            for (int k = 0; k < 3; k++) begin
               quo_ff[t][k] <= mul[t][k][wsf_pkg::DIV_SHIFT +: CB];
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sum[k] = '0;
         for (int t = 0; t < 9; t++) begin
            sum[k] = sum[k] + quo_ff[t][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (o_rdy) begin
         rsp.valid <= q_v_ff;
      end
      if (o_rdy && q_v_ff) begin
         rsp.out_red    <= 16'(sum[0]);
         rsp.out_green  <= 16'(sum[1]);
         rsp.out_blue   <= 16'(sum[2]);
         rsp.out_row    <= qtag_ff.row;
         rsp.out_col    <= qtag_ff.col;
         rsp.burst_last <= qtag_ff.last;
      end
   end

endmodule

// File: rtl/core/wsf_chk.sv
module wsf_chk (
   input logic        clock,
   input logic        reset,
   wsf_req_if.sink    req_bus,
   wsf_rsp_if.source  rsp_bus
);

   a_rst_quiet: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_bus.valid)
      else $error("output beat right after reset");

   a_rst_ready: assert property (@(posedge clock) $past(reset) && !reset |-> req_bus.ready)
      else $error("input not ready right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid)
      else $error("output beat dropped while stalled");

   a_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=>
         $stable(rsp_bus.out_red) && $stable(rsp_bus.out_green) &&
         $stable(rsp_bus.out_blue) && $stable(rsp_bus.out_row) &&
         $stable(rsp_bus.out_col) && $stable(rsp_bus.burst_last))
      else $error("output beat changed while stalled");

endmodule

bind weighted_3x3_stencil_filter_top wsf_chk u_chk (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

// File: sim/weighted_3x3_stencil_filter_top_tb.sv
module weighted_3x3_stencil_filter_top_tb;

   localparam int LINE_DEPTH = 1024;
   localparam int UNUSED_REG = 5;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_PIXELS = 140;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_beat_type;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [9:0]  row;
      logic [9:0]  col;
      logic        last;
   } filtered_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [wsf_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wsf_req_if req_bus();
   wsf_rsp_if rsp_bus();

   weighted_3x3_stencil_filter_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // filter state mirrored on the bench side
   int unsigned frame_reg = 512;
   int unsigned w_main = 60, w_mid = 30, w_far = 10, w_side = 3;
   logic [47:0] older_line[LINE_DEPTH];
   logic [47:0] newer_line[LINE_DEPTH];
   logic [47:0] window[9];
   int row_pos = 0, col_pos = 0;

   pixel_beat_type    pixel_backlog[$];
   filtered_beat_type filtered_expected[$];

   int  errors = 0;
   int  cycles = 0;
   int  pixels_sent = 0;
   bit  calm = 1'b0;
   bit  req_taken = 1'b0, rsp_taken = 1'b0;
   int  req_gap = 0, rsp_stall = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   function automatic int unsigned tap_gain(int a, int b);
      if (a == b) return a == 0 ? w_main : (a == 1 ? w_mid : w_far);
      if (a + b == 1 || a + b == 3) return w_side;
      return 0;
   endfunction

   function automatic void filter_pixel(pixel_beat_type p);
      int n, r, c, ci, rlo, rhi, clo, chi, wr, wc;
      int unsigned sum[3];
      int unsigned gain;
      logic [47:0] px, tap;
      filtered_beat_type burst[$];
      filtered_beat_type o;
      n = frame_reg == 0 ? 1 : (frame_reg > LINE_DEPTH ? LINE_DEPTH : frame_reg);
      r = row_pos;
      c = col_pos;
      ci = c & (LINE_DEPTH - 1);
      px = {p.blue, p.green, p.red};
      for (int a = 0; a < 3; a++) begin
         window[a*3] = window[a*3+1];
         window[a*3+1] = window[a*3+2];
      end
      window[2] = older_line[ci];
      window[5] = newer_line[ci];
      window[8] = px;
      older_line[ci] = newer_line[ci];
      newer_line[ci] = px;
      if (r == n - 1) begin
         rlo = r >= 2 ? r - 2 : 0;
         rhi = r;
      end else begin
         rlo = r - 2;
         rhi = r - 2;
      end
      if (c == n - 1) begin
         clo = c >= 2 ? c - 2 : 0;
         chi = c;
      end else begin
         clo = c - 2;
         chi = c - 2;
      end
      if (rlo >= 0 && clo >= 0) begin
         for (int i = rlo; i <= rhi; i++) begin
            for (int j = clo; j <= chi; j++) begin
               sum = '{0, 0, 0};
               for (int a = 0; a < 3; a++) begin
                  for (int b = 0; b < 3; b++) begin
                     wr = i + a - r + 2;
                     wc = j + b - c + 2;
                     if (i + a < n && j + b < n && wr >= 0 && wr <= 2 && wc >= 0 && wc <= 2)
                        begin
                        gain = tap_gain(a, b);
                        tap = window[wr*3+wc];
                        for (int k = 0; k < 3; k++)
                           sum[k] += (int'(tap[16*k +: 16]) * gain) / 100;
                     end
                  end
               end
               o.red = sum[0][15:0];
               o.green = sum[1][15:0];
               o.blue = sum[2][15:0];
               o.row = i[9:0];
               o.col = j[9:0];
               o.last = 1'b0;
               burst.push_back(o);
            end
         end
      end
      if (burst.size() > 0) begin
         o = burst.pop_back();
         o.last = 1'b1;
         burst.push_back(o);
      end
      foreach (burst[q]) filtered_expected.push_back(burst[q]);
      c++;
      if (c >= n) begin
         c = 0;
         r++;
         if (r >= n) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endfunction

   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      filtered_beat_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            filter_pixel('{req_bus.pixel_red, req_bus.pixel_green, req_bus.pixel_blue});
            req_taken = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            if (filtered_expected.size() == 0) begin
               $error("unexpected output beat at row %0d col %0d",
                      rsp_bus.out_row, rsp_bus.out_col);
               errors++;
            end else begin
               e = filtered_expected.pop_front();
               check_field("out_red", e.red, rsp_bus.out_red);
               check_field("out_green", e.green, rsp_bus.out_green);
               check_field("out_blue", e.blue, rsp_bus.out_blue);
               check_field("out_row", e.row, rsp_bus.out_row);
               check_field("out_col", e.col, rsp_bus.out_col);
               check_field("burst_last", e.last, rsp_bus.burst_last);
            end
         end
      end
   end

   always @(negedge clock) begin
      pixel_beat_type p;
      if (!reset && (req_taken || !req_bus.valid)) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pixel_backlog.size() > 0) begin
            p = pixel_backlog.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.pixel_red <= p.red;
            req_bus.pixel_green <= p.green;
            req_bus.pixel_blue <= p.blue;
            req_gap = draw_wait();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_stall = draw_wait();
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(int idx, int unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= wsf_pkg::CSR_AW'(idx * 4);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         wsf_pkg::REG_FRAME: begin
            frame_reg = value & 32'h7ff;
            row_pos = 0;
            col_pos = 0;
         end
         wsf_pkg::REG_MAIN: w_main = value & 32'h7f;
         wsf_pkg::REG_MID:  w_mid = value & 32'h7f;
         wsf_pkg::REG_FAR:  w_far = value & 32'h7f;
         wsf_pkg::REG_SIDE: w_side = value & 32'h7f;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic push_pixel(logic [15:0] pr, logic [15:0] pg, logic [15:0] pb);
      pixel_backlog.push_back('{pr, pg, pb});
      pixels_sent++;
   endtask

   task automatic push_random(int count);
      repeat (count) push_pixel(16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic settle();
      while (pixel_backlog.size() > 0 || req_bus.valid || filtered_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_weight();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 127;
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   initial begin
      int n, total, cut;
      req_bus.valid = 1'b0;
      req_bus.pixel_red = '0;
      req_bus.pixel_green = '0;
      req_bus.pixel_blue = '0;
      rsp_bus.ready = 1'b0;
      for (int k = 0; k < LINE_DEPTH; k++) begin
         older_line[k] = '0;
         newer_line[k] = '0;
      end
      foreach (window[k]) window[k] = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // 3x3 frame, extreme weights and pixel values
      csr_write(wsf_pkg::REG_FRAME, 3);
      csr_write(wsf_pkg::REG_MAIN, 100);
      csr_write(wsf_pkg::REG_MID, 127);
      csr_write(wsf_pkg::REG_FAR, 0);
      csr_write(wsf_pkg::REG_SIDE, 1);
      push_pixel(16'h0000, 16'hffff, 16'haaaa);
      push_pixel(16'hffff, 16'h0000, 16'h5555);
      push_pixel(16'h5555, 16'haaaa, 16'hffff);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      push_pixel(16'h0000, 16'h0000, 16'h0000);
      push_pixel(16'haaaa, 16'h5555, 16'h0001);
      push_pixel(16'h8000, 16'h7fff, 16'hffff);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      push_pixel(16'hffff, 16'h0001, 16'h8000);
      settle();
      // size zero acts as one
      csr_write(wsf_pkg::REG_FRAME, 0);
      push_random(3);
      settle();
      csr_write(wsf_pkg::REG_FRAME, 2);
      csr_write(wsf_pkg::REG_MAIN, 127);
      csr_write(wsf_pkg::REG_MID, 127);
      csr_write(wsf_pkg::REG_FAR, 127);
      csr_write(wsf_pkg::REG_SIDE, 127);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      push_pixel(16'hffff, 16'hffff, 16'hffff);
      settle();
      // oversized frame saturates, writes past the register list are dropped
      csr_write(wsf_pkg::REG_FRAME, 2047);
      csr_write(UNUSED_REG, 32'hffffffff);
      push_random(3);
      settle();
      csr_write(wsf_pkg::REG_FRAME, 1024);
      push_random(2);
      settle();

      total = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < total) begin
         n = $urandom_range(1, 6);
         calm = $urandom_range(0, 2) == 0;
         csr_write(wsf_pkg::REG_FRAME, n);
         csr_write(wsf_pkg::REG_MAIN, pick_weight());
         csr_write(wsf_pkg::REG_MID, pick_weight());
         csr_write(wsf_pkg::REG_FAR, pick_weight());
         csr_write(wsf_pkg::REG_SIDE, pick_weight());
         case ($urandom_range(0, 9))
            0, 1: push_random($urandom_range(1, n * n));
            2, 3: begin
               cut = $urandom_range(1, n * n);
               push_random(cut - 1);
               settle();
               csr_write($urandom_range(wsf_pkg::REG_MAIN, wsf_pkg::REG_SIDE), pick_weight());
               push_random(n * n - cut + 1);
            end
            default: push_random(n * n * $urandom_range(1, 2));
         endcase
         settle();
      end

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
